### hdl/ttcs_pkg.sv
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types, character constants and text lookups for the token stuffer.
// ----------------------------------------------------------------------------
package ttcs_pkg;

    localparam logic [7:0] CH_D     = 8'h64;  // d
    localparam logic [7:0] CH_L     = 8'h6C;  // l
    localparam logic [7:0] CH_E     = 8'h65;  // e
    localparam logic [7:0] CH_UE    = 8'h45;  // E
    localparam logic [7:0] CH_US    = 8'h53;  // S
    localparam logic [7:0] CH_UC    = 8'h43;  // C
    localparam logic [7:0] CH_S     = 8'h73;  // s
    localparam logic [7:0] CH_T     = 8'h74;  // t
    localparam logic [7:0] CH_X     = 8'h78;  // x
    localparam logic [7:0] CH_SPACE = 8'h20;  // space

    localparam logic MODE_STUFF   = 1'b0;
    localparam logic MODE_UNSTUFF = 1'b1;

    // what the middle segment of a result run holds
    typedef enum logic [1:0] {
        CORE_NONE = 2'd0,
        CORE_ONE  = 2'd1,   // one byte taken from core_byte
        CORE_ESCD = 2'd2,   // ESC then d
        CORE_ESC2 = 2'd3    // ESC ESC
    } t_core;

    // output sequencer segments
    typedef enum logic [3:0] {
        SEG_HDR   = 4'b0001,
        SEG_CORE  = 4'b0010,
        SEG_FLUSH = 4'b0100,
        SEG_TRL   = 4'b1000
    } t_seg;

    // everything needed to replay the results of one input beat
    typedef struct packed {
        logic       hdr;
        t_core      core;
        logic [7:0] core_byte;
        logic [1:0] flush_cnt;
        logic [7:0] flush0;
        logic [7:0] flush1;
        logic       trl;
        logic       last;
    } t_plan;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_D;
            3'd1:    c = CH_L;
            3'd2:    c = CH_E;
            3'd3:    c = CH_SPACE;
            3'd4:    c = CH_S;
            3'd5:    c = CH_T;
            3'd6:    c = CH_X;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trl_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_SPACE;
            3'd1:    c = CH_E;
            3'd2:    c = CH_T;
            3'd3:    c = CH_X;
            3'd4:    c = CH_SPACE;
            3'd5:    c = CH_D;
            3'd6:    c = CH_L;
            default: c = CH_E;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] core_char(input t_core kind, input logic [2:0] idx,
                                             input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (kind == CORE_ESCD && idx == 3'd3) begin
            c = CH_D;
        end else if (kind == CORE_ESCD || kind == CORE_ESC2) begin
            case (idx) inside
                3'd0, 3'd3: c = CH_UE;
                3'd1, 3'd4: c = CH_US;
                default:    c = CH_UC;
            endcase
        end
        return c;
    endfunction

endpackage

### hdl/text_token_char_stuffer.sv
// ----------------------------------------------------------------------------
// text_token_char_stuffer
// Frames and stuffs (sender) or unstuffs (receiver) a byte stream whose
// flag tokens are the texts dle and ESC.
// ----------------------------------------------------------------------------
//  channel | dir | tdata        | tlast      | tuser
//  s       | in  | data_byte    | frame_last | frame_first
//  m       | out | out_byte     | run_last   | frame_done
//  cfg     | in  | mode (wen/wdata, one register)
//
// an input beat is decoded in its accept cycle; the window and literal count
// update at once and a result plan is loaded into the output sequencer
// a new input beat is accepted only when the sequencer is idle or its last
// result beat is taken; the output sequencer sends one beat per cycle while i_m_tready is high
// a beat that yields no result loads no plan into the sequencer
// reset clears mode, the lookahead window and the literal count
// ----------------------------------------------------------------------------
module text_token_char_stuffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic       i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] data_byte
    input  logic       i_s_tlast,    // frame_last
    input  logic       i_s_tuser,    // [0] frame_first
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast,    // run_last
    output logic       o_m_tuser     // [0] frame_done
);

    logic       r_mode;
    logic [7:0] r_old;
    logic [7:0] r_new;
    logic [1:0] r_cnt;
    logic [1:0] r_lit;

    logic [7:0] n_old;
    logic [7:0] n_new;
    logic [1:0] n_cnt;
    logic [1:0] n_lit;

    ttcs_pkg::t_plan plan;
    logic            plan_any;
    logic            can_load;
    logic            accept;
    logic            is_dle;
    logic            is_esc;

    always_comb begin
        n_old = r_old;
        n_new = r_new;
        n_cnt = (r_cnt == 2'd3) ? 2'd2 : r_cnt;
        n_lit = r_lit;

        plan.hdr       = 1'b0;
        plan.core      = ttcs_pkg::CORE_NONE;
        plan.core_byte = i_s_tdata;
        plan.flush_cnt = 2'd0;
        plan.flush0    = 8'd0;
        plan.flush1    = 8'd0;
        plan.trl       = 1'b0;
        plan.last      = i_s_tlast;

        if (i_s_tuser) begin
            n_cnt = 2'd0;
            n_lit = 2'd0;
        end

        is_dle = (r_old == ttcs_pkg::CH_D) && (r_new == ttcs_pkg::CH_L)
              && (i_s_tdata == ttcs_pkg::CH_E);
        is_esc = (r_old == ttcs_pkg::CH_UE) && (r_new == ttcs_pkg::CH_US)
              && (i_s_tdata == ttcs_pkg::CH_UC);

        if (r_mode == ttcs_pkg::MODE_STUFF) begin
            n_lit    = 2'd0;
            plan.hdr = i_s_tuser;
            plan.trl = i_s_tlast;
            if (n_cnt == 2'd0) begin
                n_old = i_s_tdata;
                n_cnt = 2'd1;
            end else if (n_cnt == 2'd1) begin
                n_new = i_s_tdata;
                n_cnt = 2'd2;
            end else if (is_dle) begin
                plan.core = ttcs_pkg::CORE_ESCD;
                n_old     = ttcs_pkg::CH_L;
                n_new     = ttcs_pkg::CH_E;
            end else if (is_esc) begin
                plan.core = ttcs_pkg::CORE_ESC2;
                n_cnt     = 2'd0;
            end else begin
                plan.core      = ttcs_pkg::CORE_ONE;
                plan.core_byte = r_old;
                n_old          = r_new;
                n_new          = i_s_tdata;
            end
        end else begin
            if (n_lit != 2'd0) begin
                plan.core = ttcs_pkg::CORE_ONE;
                n_lit     = n_lit - 2'd1;
            end else if (n_cnt == 2'd0) begin
                n_old = i_s_tdata;
                n_cnt = 2'd1;
            end else if (n_cnt == 2'd1) begin
                n_new = i_s_tdata;
                n_cnt = 2'd2;
            end else if (is_esc) begin
                n_cnt = 2'd0;
                n_lit = 2'd3;
            end else begin
                plan.core      = ttcs_pkg::CORE_ONE;
                plan.core_byte = r_old;
                n_old          = r_new;
                n_new          = i_s_tdata;
            end
        end

        // frame end drains the window as it stands
        if (i_s_tlast) begin
            plan.flush_cnt = n_cnt;
            plan.flush0    = n_old;
            plan.flush1    = n_new;
            n_cnt          = 2'd0;
            n_lit          = 2'd0;
        end

        plan_any = plan.hdr | plan.trl | (plan.flush_cnt != 2'd0)
                 | (plan.core != ttcs_pkg::CORE_NONE);
    end

    assign o_s_tready = can_load;
    assign accept     = i_s_tvalid & can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ttcs_pkg::MODE_STUFF;
            r_old  <= 8'd0;
            r_new  <= 8'd0;
            r_cnt  <= 2'd0;
            r_lit  <= 2'd0;
        end else begin
            if (i_cfg_wen) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_old <= n_old;
                r_new <= n_new;
                r_cnt <= n_cnt;
                r_lit <= n_lit;
            end
        end
    end

    ttcs_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept & plan_any),
        .i_plan     (plan),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### hdl/ttcs_emit.sv
// ----------------------------------------------------------------------------
// ttcs_emit
// Output sequencer: replays one stored result plan, one beat per cycle while i_m_tready is high.
// ----------------------------------------------------------------------------
module ttcs_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ttcs_pkg::t_plan i_plan,
    output logic            o_can_load,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast,   // run_last
    output logic            o_m_tuser    // [0] frame_done
);

    logic            r_busy;
    ttcs_pkg::t_plan r_plan;
    ttcs_pkg::t_seg  r_seg;
    logic [2:0]      r_idx;

    ttcs_pkg::t_seg  first_seg;
    ttcs_pkg::t_seg  next_seg;
    logic            has_next;
    logic [2:0]      seg_len_m1;
    logic            beat_end;
    logic            beat_last;
    logic            take;

    // first nonempty segment of an incoming plan
    always_comb begin
        if (i_plan.hdr) begin
            first_seg = ttcs_pkg::SEG_HDR;
        end else if (i_plan.core != ttcs_pkg::CORE_NONE) begin
            first_seg = ttcs_pkg::SEG_CORE;
        end else if (i_plan.flush_cnt != 2'd0) begin
            first_seg = ttcs_pkg::SEG_FLUSH;
        end else begin
            first_seg = ttcs_pkg::SEG_TRL;
        end
    end

    always_comb begin
        next_seg = ttcs_pkg::SEG_TRL;
        has_next = 1'b0;
        case (r_seg)
            ttcs_pkg::SEG_HDR: begin
                seg_len_m1 = 3'd7;
                if (r_plan.core != ttcs_pkg::CORE_NONE) begin
                    next_seg = ttcs_pkg::SEG_CORE;
                    has_next = 1'b1;
                end else if (r_plan.flush_cnt != 2'd0) begin
                    next_seg = ttcs_pkg::SEG_FLUSH;
                    has_next = 1'b1;
                end else begin
                    has_next = r_plan.trl;
                end
            end
            ttcs_pkg::SEG_CORE: begin
                case (r_plan.core)
                    ttcs_pkg::CORE_ESCD: seg_len_m1 = 3'd3;
                    ttcs_pkg::CORE_ESC2: seg_len_m1 = 3'd5;
                    default:             seg_len_m1 = 3'd0;
                endcase
                if (r_plan.flush_cnt != 2'd0) begin
                    next_seg = ttcs_pkg::SEG_FLUSH;
                    has_next = 1'b1;
                end else begin
                    has_next = r_plan.trl;
                end
            end
            ttcs_pkg::SEG_FLUSH: begin
                seg_len_m1 = {1'b0, r_plan.flush_cnt - 2'd1};
                has_next   = r_plan.trl;
            end
            default: begin
                seg_len_m1 = 3'd7;
            end
        endcase
    end

    assign beat_end   = (r_idx == seg_len_m1);
    assign beat_last  = beat_end & ~has_next;
    assign take       = r_busy & i_m_tready;
    assign o_can_load = ~r_busy | (take & beat_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= ttcs_pkg::SEG_HDR;
            r_idx  <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_seg  <= first_seg;
            r_idx  <= 3'd0;
        end else if (take) begin
            if (beat_last) begin
                r_busy <= 1'b0;
            end else if (beat_end) begin
                r_seg <= next_seg;
                r_idx <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
        end
    end

    always_comb begin
        case (r_seg)
            ttcs_pkg::SEG_HDR:   o_m_tdata = ttcs_pkg::hdr_char(r_idx);
            ttcs_pkg::SEG_CORE:  o_m_tdata = ttcs_pkg::core_char(r_plan.core, r_idx,
                                                                 r_plan.core_byte);
            ttcs_pkg::SEG_FLUSH: o_m_tdata = r_idx[0] ? r_plan.flush1 : r_plan.flush0;
            default:             o_m_tdata = ttcs_pkg::trl_char(r_idx);
        endcase
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = beat_last;
    assign o_m_tuser  = beat_last & r_plan.last;

endmodule
